// ----- rtl/pnr_pkg.sv -----
// Package for the polynomial Newton root finder.
// Holds shared types and constants; depends on nothing.
package pnr_pkg;

	localparam int CoefW = 16;
	localparam int NumCoef = 7;
	localparam int NumRegs = 8;
	localparam int AddrW = 5;

	localparam logic [2:0] RegDegree = 3'd0;

	localparam logic [1:0] StatNoSign = 2'd0;
	localparam logic [1:0] StatConv = 2'd1;
	localparam logic [1:0] StatZeroDer = 2'd2;
	localparam logic [1:0] StatLimit = 2'd3;

	typedef logic signed [CoefW-1:0] coef_t;
	typedef coef_t [NumCoef-1:0] coef_arr_t;

	localparam coef_arr_t CoefReset = {{(NumCoef-2){16'sd0}}, 16'sd1, 16'sd0};

	typedef struct packed {
		logic [1:0] status;
		logic signed [31:0] root;
		logic [6:0] iterations;
		logic signed [31:0] residual;
	} result_t;

	typedef enum logic [3:0] {
		EngIdle,
		EngEvalA,
		EngEvalB,
		EngEvalF,
		EngEvalD,
		EngDiv,
		EngEvalN,
		EngDone
	} eng_state_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [31:0] r;
		if (v > 66'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -66'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// ----- rtl/pnr_queue.sv -----
// Two-entry queue between the front and the back of the root finder.
// Depends on pnr_pkg.
module pnr_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [31:0] in_data,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [31:0] out_data
);
	import pnr_pkg::*;

	logic signed [31:0] mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data = mem_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// ----- rtl/pnr_divider.sv -----
// Radix-2 signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on pnr_pkg.
module pnr_divider #(
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [31:0] num,
	input  logic signed [31:0] den,
	output logic done,
	output logic signed [63:0] quot
);
	import pnr_pkg::*;

	localparam int NumW = 32 + FRAC_BITS;
	localparam int CntW = $clog2(NumW + 1);

	logic [NumW-1:0] n_q;
	logic [NumW:0] rem_q;
	logic [31:0] d_q;
	logic neg_q, busy_q;
	logic [CntW-1:0] cnt_q;
	logic [NumW:0] trial;
	logic [NumW:0] num_abs;

	assign num_abs = num[31] ? (NumW+1)'(-$signed({num, {FRAC_BITS{1'b0}}}))
		: (NumW+1)'({num, {FRAC_BITS{1'b0}}});
	assign trial = {rem_q[NumW-1:0], n_q[NumW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CntW'(NumW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num_abs[NumW-1:0];
			rem_q <= '0;
			d_q <= den[31] ? 32'(-den) : den;
			neg_q <= num[31] ^ den[31];
		end else if (busy_q) begin
			if (trial >= {{(NumW-31){1'b0}}, d_q}) begin
				rem_q <= trial - {{(NumW-31){1'b0}}, d_q};
				n_q <= {n_q[NumW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				n_q <= {n_q[NumW-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		quot = neg_q ? -$signed(64'(n_q)) : $signed(64'(n_q));
	end
endmodule

// ----- rtl/pnr_engine.sv -----
// Back part: Horner evaluations on one shared multiplier and Newton steps.
// Depends on pnr_pkg and pnr_divider.
module pnr_engine #(
	parameter int MAX_DEGREE = 6,
	parameter int ITER_LIMIT = 64,
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [31:0] in_x,
	input  pnr_pkg::coef_arr_t coefs,
	input  logic [2:0] degree,
	output logic res_valid,
	input  logic res_ready,
	output pnr_pkg::result_t res
);
	import pnr_pkg::*;

	localparam int OneFx = 1 << FRAC_BITS;
	localparam int EpsRaw = (OneFx + 500) / 1000;
	localparam int EpsFx = (EpsRaw > 0) ? EpsRaw : 1;
	localparam int StepFx = (45 * OneFx + 50) / 100;

	eng_state_t state_q, state_d;
	logic [2:0] deg_eff;
	logic signed [31:0] x_q, xn_q, a_q, f_q, acc_q, ex_q;
	logic [6:0] it_q;
	logic [2:0] k_q;
	logic hstep_q, hrun_q, hload_q, hmul_q, der_q;
	logic hstart;
	logic signed [63:0] prod_q;
	logic signed [31:0] hc;
	logic signed [65:0] cterm;
	logic div_start, div_done;
	logic signed [63:0] quot;
	logic signed [31:0] xn_next;
	logic signed [32:0] dxs;
	logic conv;

	pnr_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk, .arst_n, .start(div_start), .num(f_q), .den(acc_q),
		.done(div_done), .quot(quot)
	);

	always_comb begin
		deg_eff = degree;
		if (degree == 3'd0) begin
			deg_eff = 3'd1;
		end else if (degree > 3'(MAX_DEGREE)) begin
			deg_eff = 3'(MAX_DEGREE);
		end
	end

	function automatic logic signed [31:0] coef_at(input coef_arr_t c, input logic [2:0] k,
			input logic d);
		logic signed [31:0] r;
		if (d) begin
			r = 32'(signed'(c[k + 3'd1])) * $signed({29'd0, k + 3'd1});
		end else begin
			r = 32'(signed'(c[k]));
		end
		return r;
	endfunction

	assign hc = coef_at(coefs, k_q, der_q);
	assign cterm = 66'(hc) <<< FRAC_BITS;
	assign xn_next = sat32(66'(x_q) - 66'(quot));
	assign dxs = 33'(xn_q) - 33'(x_q);
	assign conv = (dxs < 33'sd0 ? -dxs : dxs) < 33'(EpsFx)
		&& (acc_q < 0 ? -33'(acc_q) : 33'(acc_q)) < 33'(EpsFx);
	assign hstart = (state_d != state_q)
		&& (state_d inside {EngEvalA, EngEvalB, EngEvalF, EngEvalD, EngEvalN});

	always_comb begin
		state_d = state_q;
		case (state_q)
			EngIdle: if (in_valid) state_d = EngEvalA;
			EngEvalA: if (!hrun_q && hstep_q) state_d = EngEvalB;
			EngEvalB: if (!hrun_q && hstep_q) begin
				if ((a_q < 0 && acc_q > 0) || (a_q > 0 && acc_q < 0)) begin
					state_d = EngEvalF;
				end else begin
					state_d = EngDone;
				end
			end
			EngEvalF: if (!hrun_q && hstep_q) state_d = EngEvalD;
			EngEvalD: if (!hrun_q && hstep_q) begin
				state_d = (acc_q == 0) ? EngDone : EngDiv;
			end
			EngDiv: if (div_done) state_d = EngEvalN;
			EngEvalN: if (!hrun_q && hstep_q) begin
				if (conv || it_q == 7'(ITER_LIMIT)) begin
					state_d = EngDone;
				end else begin
					state_d = EngEvalF;
				end
			end
			EngDone: if (res_ready) state_d = EngIdle;
			default: state_d = EngIdle;
		endcase
	end

	always_comb begin
		in_ready = (state_q == EngIdle);
		res_valid = (state_q == EngDone);
		div_start = (state_q == EngEvalD) && !hrun_q && hstep_q && (acc_q != 0);
	end

	// Horner first loads the top coefficient, then does a multiply and a shift-add step for each further coefficient.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= EngIdle;
			hrun_q <= 1'b0;
			hload_q <= 1'b0;
			hmul_q <= 1'b0;
			hstep_q <= 1'b0;
			k_q <= '0;
			der_q <= 1'b0;
			it_q <= '0;
		end else begin
			state_q <= state_d;
			hstep_q <= 1'b0;
			if (hstart) begin
				hrun_q <= 1'b1;
				hload_q <= 1'b1;
				hmul_q <= 1'b0;
				der_q <= (state_d == EngEvalD);
				k_q <= (state_d == EngEvalD) ? deg_eff - 3'd1 : deg_eff;
			end else if (hrun_q) begin
				hload_q <= 1'b0;
				if (hmul_q) begin
					hmul_q <= 1'b0;
				end else if (k_q == 3'd0) begin
					hrun_q <= 1'b0;
					hstep_q <= 1'b1;
				end else begin
					hmul_q <= 1'b1;
					k_q <= k_q - 3'd1;
				end
			end
			if (state_q == EngIdle && in_valid) begin
				it_q <= '0;
			end else if (state_q == EngDiv && div_done) begin
				it_q <= it_q + 7'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == EngIdle && in_valid) begin
			x_q <= in_x;
			ex_q <= in_x;
		end
		if (state_q == EngEvalA && !hrun_q && hstep_q) begin
			a_q <= acc_q;
			ex_q <= sat32(66'(x_q) + 66'(StepFx));
		end
		if (state_q == EngEvalB && !hrun_q && hstep_q) begin
			ex_q <= x_q;
			res.status <= StatNoSign;
			res.root <= x_q;
			res.iterations <= '0;
			res.residual <= a_q;
		end
		if (state_q == EngEvalF && !hrun_q && hstep_q) begin
			f_q <= acc_q;
		end
		if (state_q == EngEvalD && !hrun_q && hstep_q && acc_q == 0) begin
			res.status <= StatZeroDer;
			res.root <= x_q;
			res.iterations <= it_q;
			res.residual <= f_q;
		end
		if (state_q == EngDiv && div_done) begin
			xn_q <= xn_next;
			ex_q <= xn_next;
		end
		if (state_q == EngEvalN && !hrun_q && hstep_q) begin
			x_q <= xn_q;
			ex_q <= xn_q;
			res.status <= conv ? StatConv : StatLimit;
			res.root <= xn_q;
			res.iterations <= it_q;
			res.residual <= acc_q;
		end
	end

	always_ff @(posedge clk) begin
		if (hrun_q && hmul_q) begin
			prod_q <= 64'(acc_q) * 64'(ex_q);
		end
		if (hrun_q && hload_q) begin
			acc_q <= sat32(cterm);
		end else if (hrun_q && !hmul_q) begin
			acc_q <= sat32(66'(prod_q >>> FRAC_BITS) + cterm);
		end
	end
endmodule

// ----- rtl/polynomial_newton_root_finder_unit.sv -----
// Top level of the polynomial Newton root finder.
// Holds the register file, the input queue and the engine; depends on pnr_pkg, pnr_queue and pnr_engine.
//
// Usage: start points arrive as words on start_point with valid/ready and
// go into a two-word queue; the engine takes them one at a time. Each word
// gives exactly one result word (status, root, iterations, residual).
// Degree and coefficients are written over the APB port while idle.
// Sequence from the engine taking a word: two Horner passes for the sign test,
// then per Newton step three Horner passes and a divide. One word is in the
// engine at a time. A stalled receiver holds the result; the queue still
// accepts up to two words meanwhile. Reset loads degree 1 and coef_1 = 1,
// clears the queue.
module polynomial_newton_root_finder_unit #(
	parameter int MAX_DEGREE = 6,
	parameter int ITER_LIMIT = 64,
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [pnr_pkg::AddrW-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [31:0] start_point,
	output logic out_valid,
	input  logic out_ready,
	output logic [1:0] status,
	output logic signed [31:0] root,
	output logic [6:0] iterations,
	output logic signed [31:0] residual
);
	import pnr_pkg::*;

	logic [2:0] degree_q;
	coef_arr_t coef_q;
	logic [2:0] ridx;
	logic q_valid, q_ready;
	logic signed [31:0] q_x;
	result_t res;

	assign pready = 1'b1;
	assign ridx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= 3'd1;
			coef_q <= CoefReset;
		end else if (psel && penable && pwrite) begin
			if (ridx == RegDegree) begin
				degree_q <= pwdata[2:0];
			end else begin
				coef_q[ridx - 3'd1] <= pwdata[15:0];
			end
		end
	end

	always_comb begin
		if (ridx == RegDegree) begin
			prdata = {29'd0, degree_q};
		end else begin
			prdata = 32'(signed'(coef_q[ridx - 3'd1]));
		end
	end

	pnr_queue u_queue (
		.clk, .arst_n, .in_valid, .in_ready, .in_data(start_point),
		.out_valid(q_valid), .out_ready(q_ready), .out_data(q_x)
	);

	pnr_engine #(.MAX_DEGREE(MAX_DEGREE), .ITER_LIMIT(ITER_LIMIT), .FRAC_BITS(FRAC_BITS))
		u_engine (
		.clk, .arst_n, .in_valid(q_valid), .in_ready(q_ready), .in_x(q_x),
		.coefs(coef_q), .degree(degree_q), .res_valid(out_valid),
		.res_ready(out_ready), .res(res)
	);

	assign status = res.status;
	assign root = res.root;
	assign iterations = res.iterations;
	assign residual = res.residual;

`ifndef ASSERT_OFF
	a_iter_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> iterations <= 7'(ITER_LIMIT)) else $error("iteration cap exceeded");
	a_nosign: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == StatNoSign) |-> iterations == 7'd0)
		else $error("no sign change with steps");
	a_conv: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == StatConv) |-> iterations != 7'd0)
		else $error("converged without a step");
`endif
endmodule
